>>> rtl/cdtp_pkg.sv
// ----------------------------------------------------------------------------
// cdtp_pkg
// Shared types, constants and the CRC column function for the CD-TEXT
// pack builder.
// ----------------------------------------------------------------------------
package cdtp_pkg;

  localparam int DataBytes = 12;
  localparam int DataBits  = DataBytes * 8;
  localparam int CrcBits   = DataBits + 32;          // 4 header bytes + data

  localparam logic [3:0]  CHAR_POS_MAX    = 4'd15;
  localparam logic [3:0]  LAST_DATA_INDEX = 4'd11;
  localparam logic [15:0] CRC_INVERT      = 16'hffff;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  typedef struct packed {
    logic [7:0] pack_type;
    logic [7:0] text_byte;
    logic       end_of_string;
    logic       last_string;
  } item_t;

  typedef struct packed {
    logic [7:0]          pack_type;
    logic [7:0]          track;
    logic [7:0]          seq_num;
    logic [3:0]          char_pos;
    logic [DataBits-1:0] data;
    logic                block_end;
  } pack_t;

  // CRC of a message that has only message bit k set (bit 0 sent first).
  // Evaluated at elaboration only; the CRC is linear with a zero start value.
  function automatic logic [15:0] crc_column(input int k);
    logic [15:0] c;
    logic        fb;
    c = '0;
    for (int j = 0; j < CrcBits; j++) begin
      fb = c[15] ^ (j == k);
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

>>> rtl/cdtp_packer.sv
// ----------------------------------------------------------------------------
// cdtp_packer
// Block and pack state: places characters and terminators into the open pack
// and registers a finished pack with its header.
// ----------------------------------------------------------------------------
module cdtp_packer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  cdtp_pkg::item_t item,
  output logic            item_ready,
  output logic            pack_valid,
  output cdtp_pkg::pack_t pack,
  input  logic            pack_ready
);

  logic [cdtp_pkg::DataBits-1:0] pack_data, pack_data_next;
  logic [3:0] fill_position, fill_position_next;
  logic [3:0] string_chars, string_chars_next;
  logic [7:0] current_track, current_track_next;
  logic [7:0] pack_sequence;
  logic [7:0] open_type, open_type_next;
  logic [7:0] open_track, open_track_next;
  logic [3:0] open_char_position, open_char_position_next;
  logic       block_open, block_open_next;

  logic                          fire, emit, full;
  logic [cdtp_pkg::DataBits-1:0] eff_data, data_w;
  logic [3:0]                    eff_fill, eff_chars;
  logic [7:0]                    eff_track, eff_otrack, wr_byte;
  logic [3:0]                    eff_ocpos;
  cdtp_pkg::pack_t               pack_next;

  assign item_ready = !pack_valid || pack_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    // a closed block opens a fresh pack first
    eff_data   = block_open ? pack_data          : '0;
    eff_fill   = block_open ? fill_position      : 4'd0;
    eff_chars  = block_open ? string_chars       : 4'd0;
    eff_track  = block_open ? current_track      : 8'd0;
    eff_otrack = block_open ? open_track         : 8'd0;
    eff_ocpos  = block_open ? open_char_position : 4'd0;
    open_type_next = block_open ? open_type : item.pack_type;

    wr_byte = item.end_of_string ? 8'd0 : item.text_byte;
    data_w  = eff_data;
    for (int i = 0; i < cdtp_pkg::DataBytes; i++) begin
      if (eff_fill == 4'(i)) data_w[cdtp_pkg::DataBits-1-8*i -: 8] = wr_byte;
    end
    full = (eff_fill == cdtp_pkg::LAST_DATA_INDEX);

    pack_data_next          = data_w;
    fill_position_next      = eff_fill + 4'd1;
    open_track_next         = eff_otrack;
    open_char_position_next = eff_ocpos;
    block_open_next         = 1'b1;
    current_track_next      = eff_track;
    emit                    = 1'b0;

    if (!item.end_of_string) begin
      string_chars_next = (eff_chars == cdtp_pkg::CHAR_POS_MAX) ? eff_chars
                                                                : eff_chars + 4'd1;
      if (full) begin
        emit                    = 1'b1;
        pack_data_next          = '0;
        fill_position_next      = 4'd0;
        open_track_next         = eff_track;
        open_char_position_next = string_chars_next;
      end
    end else begin
      string_chars_next  = 4'd0;
      current_track_next = eff_track + 8'd1;
      if (item.last_string) begin
        emit                    = 1'b1;
        block_open_next         = 1'b0;
        pack_data_next          = '0;
        fill_position_next      = 4'd0;
        open_track_next         = 8'd0;
        open_char_position_next = 4'd0;
      end else if (full) begin
        emit                    = 1'b1;
        pack_data_next          = '0;
        fill_position_next      = 4'd0;
        open_track_next         = current_track_next;
        open_char_position_next = 4'd0;
      end
    end

    pack_next.pack_type = open_type_next;
    pack_next.track     = eff_otrack;
    pack_next.seq_num   = pack_sequence;
    pack_next.char_pos  = eff_ocpos;
    pack_next.data      = data_w;
    pack_next.block_end = item.end_of_string && item.last_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_data          <= '0;
      fill_position      <= '0;
      string_chars       <= '0;
      current_track      <= '0;
      pack_sequence      <= '0;
      open_type          <= '0;
      open_track         <= '0;
      open_char_position <= '0;
      block_open         <= 1'b0;
      pack_valid         <= 1'b0;
    end else if (fire) begin
      pack_data          <= pack_data_next;
      fill_position      <= fill_position_next;
      string_chars       <= string_chars_next;
      current_track      <= current_track_next;
      open_type          <= open_type_next;
      open_track         <= open_track_next;
      open_char_position <= open_char_position_next;
      block_open         <= block_open_next;
      pack_valid         <= emit;
      if (emit) pack_sequence <= pack_sequence + 8'd1;
    end else if (pack_ready) begin
      pack_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) pack <= pack_next;
  end

endmodule

>>> rtl/cdtp_crc_out.sv
// ----------------------------------------------------------------------------
// cdtp_crc_out
// Parallel CRC-16 over the 16 pack bytes and the result register.
// ----------------------------------------------------------------------------
module cdtp_crc_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            pack_valid,
  input  cdtp_pkg::pack_t pack,
  output logic            pack_ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_pack_type,
  output logic [7:0]      track_number,
  output logic [7:0]      sequence_number,
  output logic [3:0]      char_position,
  output logic [63:0]     data_bytes_0_to_7,
  output logic [31:0]     data_bytes_8_to_11,
  output logic [15:0]     crc,
  output logic            block_end
);

  logic [cdtp_pkg::CrcBits-1:0] msg;
  logic [15:0]                  terms [cdtp_pkg::CrcBits];
  logic [15:0]                  crc_next;

  assign msg = {pack.pack_type, pack.track, pack.seq_num, 4'd0, pack.char_pos,
                pack.data};

  // each message bit folds in a fixed 16-bit column
  for (genvar k = 0; k < cdtp_pkg::CrcBits; k++) begin : g_col
    localparam logic [15:0] Col = cdtp_pkg::crc_column(k);
    assign terms[k] = msg[cdtp_pkg::CrcBits-1-k] ? Col : 16'h0000;
  end

  always_comb begin
    crc_next = cdtp_pkg::CRC_INVERT;
    for (int k = 0; k < cdtp_pkg::CrcBits; k++) crc_next = crc_next ^ terms[k];
  end

  assign pack_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (pack_ready) out_valid <= pack_valid;
  end

  always_ff @(posedge clk) begin
    if (pack_valid && pack_ready) begin
      out_pack_type      <= pack.pack_type;
      track_number       <= pack.track;
      sequence_number    <= pack.seq_num;
      char_position      <= pack.char_pos;
      data_bytes_0_to_7  <= pack.data[95:32];
      data_bytes_8_to_11 <= pack.data[31:0];
      crc                <= crc_next;
      block_end          <= pack.block_end;
    end
  end

endmodule

>>> rtl/cd_text_pack_builder_core.sv
// ----------------------------------------------------------------------------
// cd_text_pack_builder_core
// CD-TEXT pack builder: one character or terminator per request in, one
// 18-byte pack (header, 12 data bytes, CRC) out each time a pack is finished.
// ----------------------------------------------------------------------------
// Path: the request that finishes a pack passes the input register, then the
//   finished pack passes the pack register and then the CRC/result register.
// Throughput: one request per cycle; out_stall backs up through the stages.
// Reset: synchronous rst empties all stages and closes any open block;
//   sequence counter, track and pack contents return to zero.
module cd_text_pack_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pack_type,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  input  logic        last_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_pack_type,
  output logic [7:0]  track_number,
  output logic [7:0]  sequence_number,
  output logic [3:0]  char_position,
  output logic [63:0] data_bytes_0_to_7,
  output logic [31:0] data_bytes_8_to_11,
  output logic [15:0] crc,
  output logic        block_end
);

  logic            item_valid, item_ready, pack_valid, pack_ready;
  cdtp_pkg::item_t item;
  cdtp_pkg::pack_t pack;

  assign in_stall = item_valid && !item_ready;

  always_ff @(posedge clk) begin
    if (rst) item_valid <= 1'b0;
    else if (!in_stall) item_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.pack_type     <= pack_type;
      item.text_byte     <= text_byte;
      item.end_of_string <= end_of_string;
      item.last_string   <= last_string;
    end
  end

  cdtp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .pack_valid (pack_valid),
    .pack       (pack),
    .pack_ready (pack_ready)
  );

  cdtp_crc_out u_crc_out (
    .clk                (clk),
    .rst                (rst),
    .pack_valid         (pack_valid),
    .pack               (pack),
    .pack_ready         (pack_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pack_type      (out_pack_type),
    .track_number       (track_number),
    .sequence_number    (sequence_number),
    .char_position      (char_position),
    .data_bytes_0_to_7  (data_bytes_0_to_7),
    .data_bytes_8_to_11 (data_bytes_8_to_11),
    .crc                (crc),
    .block_end          (block_end)
  );

endmodule

>>> verif/cdtp_pack_checker.sv
// ----------------------------------------------------------------------------
// cdtp_pack_checker
// Watches the request and pack channels of the CD-TEXT pack builder, keeps
// its own copy of the packing state, predicts every finished pack with its
// header and CRC, and compares each delivered pack against the oldest one.
// ----------------------------------------------------------------------------
module cdtp_pack_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  pack_type,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  input  logic        last_string,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_pack_type,
  input  logic [7:0]  track_number,
  input  logic [7:0]  sequence_number,
  input  logic [3:0]  char_position,
  input  logic [63:0] data_bytes_0_to_7,
  input  logic [31:0] data_bytes_8_to_11,
  input  logic [15:0] crc,
  input  logic        block_end,
  output int          mismatch_count,
  output int          packs_outstanding
);

  typedef struct {
    logic [7:0]  ptype;
    logic [7:0]  track;
    logic [7:0]  seq;
    logic [3:0]  cpos;
    logic [63:0] lo_bytes;
    logic [31:0] hi_bytes;
    logic [15:0] crc;
    logic        last;
  } pack_exp_t;

  pack_exp_t   expected_packs[$];

  logic [7:0]  pend_bytes[cdtp_pkg::DataBytes];
  int          fill_idx;
  logic [3:0]  str_len;
  logic [7:0]  track_ctr;
  logic [7:0]  seq_ctr;
  logic [7:0]  blk_type;
  logic [7:0]  hdr_track;
  logic [3:0]  hdr_cpos;
  bit          blk_active;

  initial begin
    mismatch_count    = 0;
    packs_outstanding = 0;
  end

  // MSB-first CRC-16, polynomial 0x1021, one byte at a time
  function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      c = c[15] ? ({c[14:0], 1'b0} ^ cdtp_pkg::CRC_POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  task automatic open_next(input logic [7:0] trk, input logic [3:0] cpos);
    for (int i = 0; i < cdtp_pkg::DataBytes; i++)
      pend_bytes[i] = 8'h00;
    fill_idx  = 0;
    hdr_track = trk;
    hdr_cpos  = cpos;
  endtask

  task automatic close_pack(input bit last);
    pack_exp_t p;
    logic [15:0] c;
    c = 16'h0000;
    c = crc16_byte(c, blk_type);
    c = crc16_byte(c, hdr_track);
    c = crc16_byte(c, seq_ctr);
    c = crc16_byte(c, {4'h0, hdr_cpos});
    for (int i = 0; i < cdtp_pkg::DataBytes; i++)
      c = crc16_byte(c, pend_bytes[i]);
    p.ptype    = blk_type;
    p.track    = hdr_track;
    p.seq      = seq_ctr;
    p.cpos     = hdr_cpos;
    p.lo_bytes = '0;
    p.hi_bytes = '0;
    for (int i = 0; i < 8; i++)
      p.lo_bytes = {p.lo_bytes[55:0], pend_bytes[i]};
    for (int i = 8; i < cdtp_pkg::DataBytes; i++)
      p.hi_bytes = {p.hi_bytes[23:0], pend_bytes[i]};
    p.crc  = c ^ cdtp_pkg::CRC_INVERT;
    p.last = last;
    expected_packs.push_back(p);
    seq_ctr = seq_ctr + 8'd1;
  endtask

  task automatic predict_request(input logic [7:0] t, input logic [7:0] b,
                                 input logic eos, input logic last);
    if (!blk_active) begin
      blk_active = 1'b1;
      blk_type   = t;
      track_ctr  = 8'd0;
      str_len    = 4'd0;
      open_next(8'd0, 4'd0);
    end
    if (!eos) begin
      pend_bytes[fill_idx] = b;
      fill_idx++;
      if (str_len != cdtp_pkg::CHAR_POS_MAX)
        str_len = str_len + 4'd1;
      if (fill_idx == cdtp_pkg::DataBytes) begin
        close_pack(1'b0);
        open_next(track_ctr, str_len);
      end
    end else begin
      // terminator: zero spacer, next track; last_string only counts here
      pend_bytes[fill_idx] = 8'h00;
      fill_idx++;
      track_ctr = track_ctr + 8'd1;
      str_len   = 4'd0;
      if (last) begin
        close_pack(1'b1);
        blk_active = 1'b0;
        open_next(8'd0, 4'd0);
      end else if (fill_idx == cdtp_pkg::DataBytes) begin
        close_pack(1'b0);
        open_next(track_ctr, 4'd0);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    pack_exp_t p;
    if (rst) begin
      expected_packs.delete();
      seq_ctr    = 8'd0;
      track_ctr  = 8'd0;
      str_len    = 4'd0;
      blk_type   = 8'd0;
      blk_active = 1'b0;
      open_next(8'd0, 4'd0);
    end else begin
      if (in_valid && !in_stall)
        predict_request(pack_type, text_byte, end_of_string, last_string);
      if (out_valid && !out_stall) begin
        if (expected_packs.size() == 0) begin
          $error("pack delivered with none expected (seq %0h)", sequence_number);
          mismatch_count++;
        end else begin
          p = expected_packs.pop_front();
          check_field("out_pack_type", 64'(p.ptype), 64'(out_pack_type));
          check_field("track_number", 64'(p.track), 64'(track_number));
          check_field("sequence_number", 64'(p.seq), 64'(sequence_number));
          check_field("char_position", 64'(p.cpos), 64'(char_position));
          check_field("data_bytes_0_to_7", p.lo_bytes, data_bytes_0_to_7);
          check_field("data_bytes_8_to_11", 64'(p.hi_bytes), 64'(data_bytes_8_to_11));
          check_field("crc", 64'(p.crc), 64'(crc));
          check_field("block_end", 64'(p.last), 64'(block_end));
        end
      end
    end
    packs_outstanding <= expected_packs.size();
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives CD-TEXT text requests into the pack builder: a directed set of
// corner cases, then random blocks of strings with random request gaps and
// output stalls. The pack checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RunLimit  = 400000;
  localparam int ReqTarget = 1950;
  localparam int QuietTail = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pack_type = 8'h00;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        last_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_pack_type;
  logic [7:0]  track_number;
  logic [7:0]  sequence_number;
  logic [3:0]  char_position;
  logic [63:0] data_bytes_0_to_7;
  logic [31:0] data_bytes_8_to_11;
  logic [15:0] crc;
  logic        block_end;

  int          mismatch_count;
  int          packs_outstanding;
  int          cycle_count = 0;
  int          reqs_sent = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b0;
  bit          sender_gaps = 1'b0;

  always #6 clk = ~clk;

  cd_text_pack_builder_core u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .pack_type          (pack_type),
    .text_byte          (text_byte),
    .end_of_string      (end_of_string),
    .last_string        (last_string),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pack_type      (out_pack_type),
    .track_number       (track_number),
    .sequence_number    (sequence_number),
    .char_position      (char_position),
    .data_bytes_0_to_7  (data_bytes_0_to_7),
    .data_bytes_8_to_11 (data_bytes_8_to_11),
    .crc                (crc),
    .block_end          (block_end)
  );

  cdtp_pack_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .pack_type          (pack_type),
    .text_byte          (text_byte),
    .end_of_string      (end_of_string),
    .last_string        (last_string),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pack_type      (out_pack_type),
    .track_number       (track_number),
    .sequence_number    (sequence_number),
    .char_position      (char_position),
    .data_bytes_0_to_7  (data_bytes_0_to_7),
    .data_bytes_8_to_11 (data_bytes_8_to_11),
    .crc                (crc),
    .block_end          (block_end),
    .mismatch_count     (mismatch_count),
    .packs_outstanding  (packs_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RunLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic set_idling(input bit on);
    sender_gaps = on;
    idle_on <= on;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_req(input logic [7:0] t, input logic [7:0] b,
                          input logic eos, input logic last);
    int gap;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    pack_type     <= t;
    text_byte     <= b;
    end_of_string <= eos;
    last_string   <= last;
    do @(posedge clk); while (in_stall);
    reqs_sent++;
  endtask

  // characters carry a random type and now and then a stray last_string
  task automatic send_text(input int len);
    for (int i = 0; i < len; i++)
      send_req(rnd8(), rnd8(), 1'b0, $urandom_range(0, 7) == 0);
  endtask

  task automatic send_term(input bit last);
    send_req(rnd8(), rnd8(), 1'b1, last);
  endtask

  task automatic drain_packs();
    in_valid <= 1'b0;
    do @(posedge clk); while (packs_outstanding != 0);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10)
      return $urandom_range(0, 3);
    else if (r < 17)
      return $urandom_range(4, 14);
    return $urandom_range(15, 40);
  endfunction

  initial begin
    int nstr;
    int blk;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // a lone last terminator opens and closes a block
    send_req(8'hff, 8'hff, 1'b1, 1'b1);
    // 11 chars then last terminator: full pack emitted once as block end
    send_req(8'h00, 8'hff, 1'b0, 1'b1);
    send_req(8'hff, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 9; i++)
      send_req(rnd8(), (i % 2) ? 8'h00 : 8'hff, 1'b0, 1'b1);
    send_req(8'h00, 8'h55, 1'b1, 1'b1);
    // 11 chars then plain terminator fills the pack, next pack on track 1
    send_req(8'h80, 8'haa, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++)
      send_req(rnd8(), rnd8(), 1'b0, 1'b0);
    send_term(1'b0);
    send_term(1'b1);
    drain_packs();

    blk = 0;
    while (reqs_sent < ReqTarget) begin
      if (reqs_sent >= ReqTarget - QuietTail)
        set_idling(1'b0);
      else
        set_idling($urandom_range(0, 4) != 0);
      if (blk == 12) begin
        // enough strings in one block to wrap the track counter
        for (int s = 0; s < 260; s++) begin
          send_text(($urandom_range(0, 5) == 0) ? 1 : 0);
          send_term(1'b0);
        end
        send_term(1'b1);
      end else if ($urandom_range(0, 99) < 35) begin
        send_term(1'b1);
      end else begin
        nstr = $urandom_range(1, 2);
        for (int s = 0; s < nstr; s++) begin
          send_text(pick_len());
          send_term(s == nstr - 1);
        end
      end
      if (blk % 40 == 20)
        drain_packs();
      blk++;
    end

    drain_packs();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/cdtp_pkg.sv
rtl/cdtp_packer.sv
rtl/cdtp_crc_out.sv
rtl/cd_text_pack_builder_core.sv
verif/cdtp_pack_checker.sv
verif/tb_top.sv
